// ===== sv/q16alu_pkg.sv =====
`timescale 1ns / 1ps

package q16alu_pkg;

    // Operation codes carried in tuser
    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } t_kind;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned FRAC_BITS = 15;
    // floor(2^30 / mag) fits in 31 bits: one quotient bit per divider stage
    localparam int unsigned QUOT_W    = 31;
    localparam int unsigned DIV_STEPS = QUOT_W;
    localparam int unsigned PROD_W    = 2 * DATA_W;
    // Product bits that must all match the sign for an in-range result
    localparam int unsigned HI_LSB    = DATA_W - 1 + FRAC_BITS;

    // Payload that travels down the pipeline with each item
    typedef struct packed {
        t_kind                     kind;
        logic signed [DATA_W-1:0]  a;
        logic        [DATA_W-1:0]  b;
        logic                      neg;
        logic                      zero;
        logic        [DATA_W-1:0]  mag;
        logic        [DATA_W-1:0]  alu_res;
        logic                      alu_ov;
        logic        [QUOT_W-1:0]  quot;
    } t_carry;

endpackage

// ===== sv/q16alu_recip.sv =====
`timescale 1ns / 1ps

// Restoring reciprocal divider: floor(2^30 / mag), one quotient bit per stage.
module q16alu_recip import q16alu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_vld,
    input  t_carry i_carry,
    output logic   o_vld,
    output t_carry o_carry
);

    logic                w_vld [0:DIV_STEPS];
    t_carry              w_c   [0:DIV_STEPS];
    logic [DATA_W-1:0]   w_rem [0:DIV_STEPS];

    assign w_vld[0] = i_vld;
    assign w_c[0]   = i_carry;
    assign w_rem[0] = '0;

    for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_step
        // Dividend 2^30 has its only set bit in the first step
        localparam logic LEAD = (gi == 0);

        logic [DATA_W-1:0] w_try;
        logic              w_ge;
        t_carry            n_c;
        logic              r_vld;
        t_carry            r_c;
        logic [DATA_W-1:0] r_rem;

        assign w_try = {w_rem[gi][DATA_W-2:0], LEAD};
        assign w_ge  = (w_try >= w_c[gi].mag);

        // Payload with this stage's quotient bit filled in
        always_comb begin
            n_c                       = w_c[gi];
            n_c.quot[QUOT_W-1-gi]     = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_adv) begin
                r_vld <= w_vld[gi];
            end
        end

        // Quotient bit and partial remainder
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_c   <= n_c;
                r_rem <= w_ge ? (w_try - w_c[gi].mag) : w_try;
            end
        end

        assign w_vld[gi+1] = r_vld;
        assign w_c[gi+1]   = r_c;
        assign w_rem[gi+1] = r_rem;
    end

    assign o_vld   = w_vld[DIV_STEPS];
    assign o_carry = w_c[DIV_STEPS];

endmodule

// ===== sv/q16alu_qmul.sv =====
`timescale 1ns / 1ps

// Q-multiply, overflow check, result select and final negation (3 stages).
module q16alu_qmul import q16alu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_vld,
    input  t_carry            i_carry,
    output logic              o_vld,
    output logic [DATA_W-1:0] o_res,
    output logic              o_ov
);

    logic signed [DATA_W-1:0] w_mb;
    logic                     r_m1_vld;
    t_carry                   r_m1_c;
    logic signed [PROD_W-1:0] r_prod;

    logic [DATA_W-1:0]        w_qres;
    logic                     w_qov;
    logic [DATA_W-1:0]        n_m2_res;
    logic                     n_m2_ov;
    logic                     r_m2_vld;
    logic [DATA_W-1:0]        r_m2_res;
    logic                     r_m2_ov;
    logic                     r_m2_neg;

    logic                     r_m3_vld;
    logic [DATA_W-1:0]        r_m3_res;
    logic                     r_m3_ov;

    // Stage 1: signed product; divide uses the reciprocal
    assign w_mb = (i_carry.kind == KIND_DIV) ? signed'({1'b0, i_carry.quot})
                                             : signed'(i_carry.b);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m1_c <= i_carry;
            r_prod <= i_carry.a * w_mb;
        end
    end

    // Stage 2: shift by 15, overflow when bits above the result disagree with its sign; select per kind
    assign w_qres = r_prod[HI_LSB:FRAC_BITS];
    assign w_qov  = !((&r_prod[PROD_W-1:HI_LSB]) || !(|r_prod[PROD_W-1:HI_LSB]));

    always_comb begin
        n_m2_res = r_m1_c.alu_res;
        n_m2_ov  = r_m1_c.alu_ov;
        case (r_m1_c.kind)
            KIND_ADD, KIND_SUB: begin
                n_m2_res = r_m1_c.alu_res;
                n_m2_ov  = r_m1_c.alu_ov;
            end
            KIND_MUL: begin
                n_m2_res = w_qres;
                n_m2_ov  = w_qov;
            end
            KIND_DIV: begin
                n_m2_res = r_m1_c.zero ? '0 : w_qres;
                n_m2_ov  = r_m1_c.zero ? 1'b1 : w_qov;
            end
            default: begin
                n_m2_res = r_m1_c.alu_res;
                n_m2_ov  = r_m1_c.alu_ov;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m2_res <= n_m2_res;
            r_m2_ov  <= n_m2_ov;
            r_m2_neg <= (r_m1_c.kind == KIND_DIV) && r_m1_c.neg && !r_m1_c.zero;
        end
    end

    // Stage 3: negative divisor flips the sign, wrapping, flag untouched
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m3_res <= r_m2_neg ? (DATA_W'(0) - r_m2_res) : r_m2_res;
            r_m3_ov  <= r_m2_ov;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_m3_vld <= 1'b0;
        end else if (i_adv) begin
            r_m1_vld <= i_vld;
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= r_m2_vld;
        end
    end

    assign o_vld = r_m3_vld;
    assign o_res = r_m3_res;
    assign o_ov  = r_m3_ov;

endmodule

// ===== sv/q16_15_fixed_point_alu.sv =====
`timescale 1ns / 1ps

// Q16.15 fixed-point ALU (add, subtract, multiply, divide) on 32-bit signed
// operands, one result item per input item. Fully pipelined: one item can
// enter every cycle unless the output stalls, and each item passes through
// one input stage, the 31-stage reciprocal divider (one quotient bit per
// stage) and three multiply/finish stages; all operations take that same
// path so items leave in order. A stall on the output freezes the whole
// pipeline, and input ready drops while the output holds an untaken item.
module q16_15_fixed_point_alu import q16alu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // [31:0] operand_a, [63:32] operand_b
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [31:0] result
    output logic [0:0]  o_m_axis_tuser   // [0] overflow
);

    logic              w_adv;
    logic [DATA_W-1:0] w_a;
    logic [DATA_W-1:0] w_b;
    logic [DATA_W-1:0] w_sum;
    logic [DATA_W-1:0] w_diff;
    t_kind             w_kind;
    t_carry            n_s0;
    t_carry            r_s0;
    logic              r_s0_vld;
    logic              w_div_vld;
    t_carry            w_div_c;
    logic              w_out_vld;
    logic [DATA_W-1:0] w_out_res;
    logic              w_out_ov;

    // Pipeline moves when the output register is free or being taken
    assign w_adv           = !w_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    assign w_a    = i_s_axis_tdata[DATA_W-1:0];
    assign w_b    = i_s_axis_tdata[2*DATA_W-1:DATA_W];
    assign w_kind = t_kind'(i_s_axis_tuser);
    assign w_sum  = w_a + w_b;
    assign w_diff = w_a - w_b;

    // Input stage: add/subtract with signed overflow, divisor magnitude
    always_comb begin
        n_s0         = '0;
        n_s0.kind    = w_kind;
        n_s0.a       = signed'(w_a);
        n_s0.b       = w_b;
        n_s0.neg     = w_b[DATA_W-1];
        n_s0.zero    = (w_b == '0);
        n_s0.mag     = w_b[DATA_W-1] ? (DATA_W'(0) - w_b) : w_b;
        n_s0.alu_res = (w_kind == KIND_SUB) ? w_diff : w_sum;
        if (w_kind == KIND_SUB) begin
            n_s0.alu_ov = (w_a[DATA_W-1] != w_b[DATA_W-1])
                       && (w_diff[DATA_W-1] != w_a[DATA_W-1]);
        end else begin
            n_s0.alu_ov = (w_a[DATA_W-1] == w_b[DATA_W-1])
                       && (w_sum[DATA_W-1] != w_a[DATA_W-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_adv) begin
            r_s0_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0 <= n_s0;
        end
    end

    q16alu_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r_s0_vld),
        .i_carry (r_s0),
        .o_vld   (w_div_vld),
        .o_carry (w_div_c)
    );

    q16alu_qmul u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_div_vld),
        .i_carry (w_div_c),
        .o_vld   (w_out_vld),
        .o_res   (w_out_res),
        .o_ov    (w_out_ov)
    );

    assign o_m_axis_tvalid   = w_out_vld;
    assign o_m_axis_tdata    = w_out_res;
    assign o_m_axis_tuser[0] = w_out_ov;

endmodule

// ===== sv/q16alu_chk.sv =====
`timescale 1ns / 1ps

// Port-level checks on the fixed-point ALU
module q16alu_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [63:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // Input is taken exactly when the output stage can move
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow output stall");

    // A stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result item changed");

endmodule

bind q16_15_fixed_point_alu q16alu_chk u_q16alu_chk (.*);
